// ===== design/rme_pkg.sv =====
package rme_pkg;

    // Rotation orders
    typedef enum logic [2:0] {
        ORD_XYZ = 3'd0,
        ORD_YXZ = 3'd1,
        ORD_ZXY = 3'd2,
        ORD_ZYX = 3'd3,
        ORD_YZX = 3'd4,
        ORD_XZY = 3'd5
    } t_order;

    typedef struct packed {
        logic [2:0]         opcode;
        logic signed [15:0] m_r1c1;
        logic signed [15:0] m_r1c2;
        logic signed [15:0] m_r1c3;
        logic signed [15:0] m_r2c1;
        logic signed [15:0] m_r2c2;
        logic signed [15:0] m_r2c3;
        logic signed [15:0] m_r3c1;
        logic signed [15:0] m_r3c2;
        logic signed [15:0] m_r3c3;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
        logic               degenerate;
    } t_out_item;

    // Fraction bits of the matrix elements (Q1.14)
    localparam int MATRIX_FRAC_BITS = 14;

    // Angle word: 30 fraction bits, range a little past +-2*pi
    localparam int ANG_W = 34;
    localparam logic signed [ANG_W-1:0] ANG_PI = 34'sd3373259426;
    localparam logic signed [ANG_W-1:0] OUT_MAX = 34'sd25736;

    // atan(2^-i) with 30 fraction bits
    function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
        logic [31:0] t [32];
        t[0]  = 32'd843314857;  t[1]  = 32'd497837829;  t[2]  = 32'd263043837;
        t[3]  = 32'd133525159;  t[4]  = 32'd67021687;   t[5]  = 32'd33543516;
        t[6]  = 32'd16775851;   t[7]  = 32'd8388437;    t[8]  = 32'd4194283;
        t[9]  = 32'd2097149;    t[10] = 32'd1048576;    t[11] = 32'd524288;
        t[12] = 32'd262144;     t[13] = 32'd131072;     t[14] = 32'd65536;
        t[15] = 32'd32768;      t[16] = 32'd16384;      t[17] = 32'd8192;
        t[18] = 32'd4096;       t[19] = 32'd2048;       t[20] = 32'd1024;
        t[21] = 32'd512;        t[22] = 32'd256;        t[23] = 32'd128;
        t[24] = 32'd64;         t[25] = 32'd32;         t[26] = 32'd16;
        t[27] = 32'd8;          t[28] = 32'd4;          t[29] = 32'd2;
        t[30] = 32'd1;          t[31] = 32'd0;
        return ANG_W'($signed({2'b00, t[i]}));
    endfunction

endpackage

// ===== design/rme_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x), one register per step.
module rme_cordic
    import rme_pkg::*;
#(
    parameter int STEPS = 16,
    parameter int IN_W  = 34,
    parameter int TAG_W = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic signed [IN_W-1:0]  i_y,
    input  logic signed [IN_W-1:0]  i_x,
    input  logic [TAG_W-1:0]        i_tag,
    output logic signed [ANG_W-1:0] o_ang,
    output logic [TAG_W-1:0]        o_tag
);
    localparam int NS = (STEPS < 32) ? STEPS : 32;
    // x grows by up to 1.65 and the sign swap adds a bit
    localparam int W = IN_W + 19;

    logic signed [W-1:0]     r_x [NS+1];
    logic signed [W-1:0]     r_y [NS+1];
    logic signed [ANG_W-1:0] r_z [NS+1];
    logic [TAG_W-1:0]        r_t [NS+1];

    // Pre-rotate into the right half-plane and scale by 2^16
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_x < 0) begin
                r_x[0] <= -(W'(i_x) <<< 16);
                r_y[0] <= -(W'(i_y) <<< 16);
                r_z[0] <= (i_y >= 0) ? ANG_PI : -ANG_PI;
            end else begin
                r_x[0] <= W'(i_x) <<< 16;
                r_y[0] <= W'(i_y) <<< 16;
                r_z[0] <= '0;
            end
            r_t[0] <= i_tag;
        end
    end

    // One micro-rotation per stage
    for (genvar g = 0; g < NS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (r_y[g] > 0) begin
                    r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] + atan_entry(g);
                end else if (r_y[g] < 0) begin
                    r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                    r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                    r_z[g+1] <= r_z[g] - atan_entry(g);
                end else begin
                    r_x[g+1] <= r_x[g];
                    r_y[g+1] <= r_y[g];
                    r_z[g+1] <= r_z[g];
                end
                r_t[g+1] <= r_t[g];
            end
        end
    end

    assign o_ang = r_z[NS];
    assign o_tag = r_t[NS];

    logic unused_rst;
    assign unused_rst = i_rst_n;
endmodule

// ===== design/rotation_matrix_to_euler_top.sv =====
// Channel  | Signals                        | Dir | Meaning
// in       | i_valid, o_ready, i_data       | in  | order and matrix item
// out      | o_valid, i_ready, o_data       | out | three angles and flag item
// config   | i_cfg_we, i_cfg_data           | in  | gimbal threshold write
//
// One item per cycle while the output is not stalled. Stages in order: operand select,
// radicand, a bit-per-stage square root (MATRIX_FRAC_BITS + 1 stages), CORDIC_STEPS + 1
// CORDIC stages and the output register. Reset clears valid bits and sets the threshold
// to 16384.
// A stall at the output freezes the whole pipeline.
module rotation_matrix_to_euler_top
    import rme_pkg::*;
#(
    parameter int CORDIC_STEPS     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_item    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_item   o_data,
    input  logic        i_cfg_we,
    input  logic [14:0] i_cfg_data
);
    localparam int NS   = (CORDIC_STEPS < 32) ? CORDIC_STEPS : 32;
    localparam int F    = MATRIX_FRAC_BITS;
    localparam int SQW  = 2 * F + 2;        // width of ONE^2 - s^2
    localparam int RTW  = F + 1;            // root bits
    localparam int SQS  = F + 1;            // root stages
    localparam int CL   = NS + 1;           // CORDIC stages
    localparam int LAT  = 2 + SQS + CL + 1; // total pipeline stages
    localparam int TW   = 1 + 3 + 1;        // valid, order, flag

    logic [14:0] r_thr;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_thr <= 15'd16384;
        else if (i_cfg_we) r_thr <= i_cfg_data;
    end

    logic adv;
    assign adv     = !o_valid || i_ready;
    assign o_ready = adv;

    // Stage A: choose operands per order
    logic signed [16:0] n_s, n_y1, n_x1, n_y2, n_x2, n_tst;
    logic               n_ok;
    always_comb begin
        n_s = '0; n_tst = '0;
        n_ok = 1'b1;
        unique case (i_data.opcode)
            ORD_XYZ: begin
                n_s = i_data.m_r1c3; n_tst = i_data.m_r1c3;
            end
            ORD_YXZ: begin
                n_s = -17'(i_data.m_r2c3); n_tst = i_data.m_r2c3;
            end
            ORD_ZXY: begin
                n_s = i_data.m_r3c2; n_tst = i_data.m_r3c2;
            end
            ORD_ZYX: begin
                n_s = -17'(i_data.m_r3c1); n_tst = i_data.m_r3c1;
            end
            ORD_YZX: begin
                n_s = i_data.m_r2c1; n_tst = i_data.m_r2c1;
            end
            ORD_XZY: begin
                n_s = -17'(i_data.m_r1c2); n_tst = i_data.m_r1c2;
            end
            default: n_ok = 1'b0;
        endcase
    end

    logic        n_deg;
    logic [16:0] tst_abs;
    assign tst_abs = n_tst[16] ? 17'(-n_tst) : 17'(n_tst);
    assign n_deg   = n_ok && (tst_abs >= {2'b00, r_thr});

    // Atan2 pairs, degenerate set substituted
    always_comb begin
        n_y1 = '0; n_x1 = '0; n_y2 = '0; n_x2 = '0;
        unique case (i_data.opcode)
            ORD_XYZ: begin
                if (!n_deg) begin
                    n_y1 = -17'(i_data.m_r2c3); n_x1 = i_data.m_r3c3;
                    n_y2 = -17'(i_data.m_r1c2); n_x2 = i_data.m_r1c1;
                end else begin
                    n_y1 = i_data.m_r3c2; n_x1 = i_data.m_r2c2;
                end
            end
            ORD_YXZ: begin
                if (!n_deg) begin
                    n_y1 = i_data.m_r1c3; n_x1 = i_data.m_r3c3;
                    n_y2 = i_data.m_r2c1; n_x2 = i_data.m_r2c2;
                end else begin
                    n_y1 = -17'(i_data.m_r3c1); n_x1 = i_data.m_r1c1;
                end
            end
            ORD_ZXY: begin
                if (!n_deg) begin
                    n_y1 = -17'(i_data.m_r3c1); n_x1 = i_data.m_r3c3;
                    n_y2 = -17'(i_data.m_r1c2); n_x2 = i_data.m_r2c2;
                end else begin
                    n_y2 = i_data.m_r2c1; n_x2 = i_data.m_r1c1;
                end
            end
            ORD_ZYX: begin
                if (!n_deg) begin
                    n_y1 = i_data.m_r3c2; n_x1 = i_data.m_r3c3;
                    n_y2 = i_data.m_r2c1; n_x2 = i_data.m_r1c1;
                end else begin
                    n_y2 = -17'(i_data.m_r1c2); n_x2 = i_data.m_r2c2;
                end
            end
            ORD_YZX: begin
                if (!n_deg) begin
                    n_y1 = -17'(i_data.m_r2c3); n_x1 = i_data.m_r2c2;
                    n_y2 = -17'(i_data.m_r3c1); n_x2 = i_data.m_r1c1;
                end else begin
                    n_y2 = i_data.m_r1c3; n_x2 = i_data.m_r3c3;
                end
            end
            ORD_XZY: begin
                if (!n_deg) begin
                    n_y1 = i_data.m_r3c2; n_x1 = i_data.m_r2c2;
                    n_y2 = i_data.m_r1c3; n_x2 = i_data.m_r1c1;
                end else begin
                    n_y1 = -17'(i_data.m_r2c3); n_x1 = i_data.m_r3c3;
                end
            end
            default: ;
        endcase
    end

    // Register A: clamp s, hold pairs
    localparam logic signed [16:0] ONE_S = 17'sd1 <<< F;
    logic signed [16:0] r_a_s, r_a_y1, r_a_x1, r_a_y2, r_a_x2;
    logic [TW-1:0]      r_a_t;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_a_t[TW-1] <= 1'b0;
        else if (adv) r_a_t[TW-1] <= i_valid;
        if (adv) begin
            r_a_s  <= (n_s > ONE_S) ? ONE_S : ((n_s < -ONE_S) ? -ONE_S : n_s);
            r_a_y1 <= n_y1; r_a_x1 <= n_x1; r_a_y2 <= n_y2; r_a_x2 <= n_x2;
            r_a_t[TW-2:0] <= {i_data.opcode, n_deg};
        end
    end

    // Register B: radicand ONE^2 - s^2
    logic [SQW-1:0]     r_b_rad;
    logic signed [16:0] r_b_s;
    logic signed [33:0] sq;
    assign sq = 34'(r_a_s) * 34'(r_a_s);
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_rad <= SQW'((34'sd1 <<< (2 * F)) - sq);
            r_b_s   <= r_a_s;
        end
    end

    // Restoring square root, one result bit per stage
    logic [SQW-1:0]     r_q_rem [SQS+1];
    logic [RTW-1:0]     r_q_rt  [SQS+1];
    logic signed [16:0] r_q_s   [SQS+1];
    always_comb begin
        r_q_rem[0] = r_b_rad; r_q_rt[0] = '0; r_q_s[0] = r_b_s;
    end
    for (genvar k = 0; k < SQS; k++) begin : g_sqrt
        localparam int B = SQS - 1 - k;
        logic [SQW+1:0] trial;
        assign trial = ({2'b00, r_q_rem[k]})
                       - ((({2'b00, SQW'(r_q_rt[k])}) << (B + 1))
                          + ((SQW + 2)'(1) << (2 * B)));
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!trial[SQW+1]) begin
                    r_q_rem[k+1] <= trial[SQW-1:0];
                    r_q_rt[k+1]  <= r_q_rt[k] | (RTW'(1) << B);
                end else begin
                    r_q_rem[k+1] <= r_q_rem[k];
                    r_q_rt[k+1]  <= r_q_rt[k];
                end
                r_q_s[k+1] <= r_q_s[k];
            end
        end
    end

    // Delay pairs and tag to line up with register B and the root stages
    logic signed [16:0] r_d_y1 [SQS+1];
    logic signed [16:0] r_d_x1 [SQS+1];
    logic signed [16:0] r_d_y2 [SQS+1];
    logic signed [16:0] r_d_x2 [SQS+1];
    logic [TW-1:0]      r_d_t  [SQS+1];
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= SQS; j++) r_d_t[j][TW-1] <= 1'b0;
        end else if (adv) begin
            r_d_y1[0] <= r_a_y1; r_d_x1[0] <= r_a_x1;
            r_d_y2[0] <= r_a_y2; r_d_x2[0] <= r_a_x2;
            r_d_t[0]  <= r_a_t;
            for (int j = 0; j < SQS; j++) begin
                r_d_y1[j+1] <= r_d_y1[j]; r_d_x1[j+1] <= r_d_x1[j];
                r_d_y2[j+1] <= r_d_y2[j]; r_d_x2[j+1] <= r_d_x2[j];
                r_d_t[j+1]  <= r_d_t[j];
            end
        end
    end

    // Three CORDIC lanes
    logic signed [ANG_W-1:0] ang_s, ang_1, ang_2;
    logic [TW-1:0]           tag_s, tag_1, tag_2;
    localparam int CIW = F + 3;
    logic signed [CIW-1:0] root_x;
    assign root_x = $signed({2'b00, r_q_rt[SQS]});

    rme_cordic #(.STEPS(CORDIC_STEPS), .IN_W(CIW), .TAG_W(TW)) u_asin (
        .i_clk, .i_rst_n, .i_en(adv),
        .i_y(CIW'(r_q_s[SQS])), .i_x(root_x), .i_tag(r_d_t[SQS]),
        .o_ang(ang_s), .o_tag(tag_s)
    );
    rme_cordic #(.STEPS(CORDIC_STEPS), .IN_W(17), .TAG_W(TW)) u_at1 (
        .i_clk, .i_rst_n, .i_en(adv),
        .i_y(r_d_y1[SQS]), .i_x(r_d_x1[SQS]), .i_tag(r_d_t[SQS]),
        .o_ang(ang_1), .o_tag(tag_1)
    );
    rme_cordic #(.STEPS(CORDIC_STEPS), .IN_W(17), .TAG_W(TW)) u_at2 (
        .i_clk, .i_rst_n, .i_en(adv),
        .i_y(r_d_y2[SQS]), .i_x(r_d_x2[SQS]), .i_tag(r_d_t[SQS]),
        .o_ang(ang_2), .o_tag(tag_2)
    );

    // CORDIC tags carry no reset; track valid separately
    logic [CL-1:0] r_cv;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= '0;
        else if (adv) r_cv <= {r_cv[CL-2:0], r_d_t[SQS][TW-1]};
    end

    function automatic logic signed [15:0] to_out(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W-1:0] q;
        q = (z + 34'sd65536) >>> 17;
        if (q > OUT_MAX) q = OUT_MAX;
        if (q < -OUT_MAX) q = -OUT_MAX;
        return q[15:0];
    endfunction

    // Route lanes to axes and round
    t_out_item n_out;
    logic signed [ANG_W-1:0] ax, ay, az;
    always_comb begin
        ax = '0; ay = '0; az = '0;
        unique case (t_order'(tag_s[3:1]))
            ORD_XYZ: begin ay = ang_s; ax = ang_1; az = ang_2; end
            ORD_YXZ: begin ax = ang_s; ay = ang_1; az = ang_2; end
            ORD_ZXY: begin ax = ang_s; ay = ang_1; az = ang_2; end
            ORD_ZYX: begin ay = ang_s; ax = ang_1; az = ang_2; end
            ORD_YZX: begin az = ang_s; ax = ang_1; ay = ang_2; end
            ORD_XZY: begin az = ang_s; ax = ang_1; ay = ang_2; end
            default: ;
        endcase
        n_out.angle_x    = to_out(ax);
        n_out.angle_y    = to_out(ay);
        n_out.angle_z    = to_out(az);
        n_out.degenerate = tag_s[0];
    end

    logic unused_tags;
    assign unused_tags = ^{tag_1, tag_2, tag_s[TW-1], LAT[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (adv) o_valid <= r_cv[CL-1];
        if (adv) o_data <= n_out;
    end
endmodule
